// ===== sv/iida_pkg.sv =====
package iida_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int WORD_W     = 32;
    localparam int IDX_MAX_W  = 11;

    localparam logic [WORD_W-1:0] ERR_WORD = 32'hFFFF_FC19;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 ins_en;
        logic                 upd_en;
        logic                 del_en;
        logic [IDX_MAX_W-1:0] index;
        logic [WORD_W-1:0]    value;
    } cell_cmd_t;

endpackage

// ===== sv/iida_if.sv =====
interface iida_req_if #(
    parameter int IDX_W = 7
) ();
    logic                             valid;
    logic                             ready;
    logic [1:0]                       action;
    logic [IDX_W-1:0]                 index;
    logic signed [iida_pkg::WORD_W-1:0] value;

    modport source (output valid, action, index, value, input ready);
    modport sink   (input valid, action, index, value, output ready);
endinterface

interface iida_rsp_if #(
    parameter int IDX_W = 7
) ();
    logic                             valid;
    logic                             ready;
    logic signed [iida_pkg::WORD_W-1:0] data;
    logic [1:0]                       status;
    logic [IDX_W-1:0]                 count;

    modport source (output valid, data, status, count, input ready);
    modport sink   (input valid, data, status, count, output ready);
endinterface

// ===== sv/indexed_insert_delete_array.sv =====
// Indexed insert/delete array.
// req channel: one beat per request (action, index, value). Actions are
// insert at index 0..count, update, delete and read at index below count.
// rsp channel: exactly one beat per request carrying data (word read or
// deleted, zero for insert/update, -999 on error), status and the count
// after the request.
// Every entry lives in its own cell; insert and delete shift every entry
// at or above the index by one cell, with all cells moving together.
// Latency: the response beat is valid the cycle after the request beat.
// Throughput: one request per cycle while rsp.ready is high.
// When the receiver stalls, the response is held in the output register
// and req.ready drops until it is taken.
// Reset clears the count and the output valid; entry contents stay
// undefined until written, and no live entry is ever unwritten.
module indexed_insert_delete_array #(
    parameter int DEPTH = iida_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    iida_req_if.sink          req,
    iida_rsp_if.source        rsp
);

    localparam logic [IDX_W-1:0] DEPTH_L = IDX_W'(DEPTH);

    logic [IDX_W-1:0]            count_reg;
    logic [IDX_W-1:0]            count_next;
    logic                        out_valid_reg;
    logic [iida_pkg::WORD_W-1:0] out_data_reg;
    logic [iida_pkg::WORD_W-1:0] out_data_next;
    iida_pkg::status_t           out_status_reg;
    iida_pkg::status_t           out_status_next;
    logic [IDX_W-1:0]            out_count_reg;

    logic                        accept;
    iida_pkg::action_t           act;
    iida_pkg::cell_cmd_t         cmd;
    logic [iida_pkg::WORD_W-1:0] rd_bus;
    logic [iida_pkg::WORD_W-1:0] words    [DEPTH];
    logic [iida_pkg::WORD_W-1:0] rd_words [DEPTH];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign act       = iida_pkg::action_t'(req.action);

    always_comb
    begin
        out_status_next = iida_pkg::ST_OK;
        out_data_next   = iida_pkg::ERR_WORD;
        count_next      = count_reg;
        cmd.ins_en      = 1'b0;
        cmd.upd_en      = 1'b0;
        cmd.del_en      = 1'b0;
        cmd.index       = iida_pkg::IDX_MAX_W'(req.index);
        cmd.value       = req.value;
        if (act == iida_pkg::ACT_INSERT)
        begin
            priority if (req.index > count_reg)
                out_status_next = iida_pkg::ST_RANGE;
            else if (count_reg >= DEPTH_L)
                out_status_next = iida_pkg::ST_FULL;
            else
            begin
                cmd.ins_en    = accept;
                out_data_next = '0;
                count_next    = count_reg + 1'b1;
            end
        end
        else
        begin
            priority if (count_reg == '0)
                out_status_next = iida_pkg::ST_EMPTY;
            else if (req.index >= count_reg)
                out_status_next = iida_pkg::ST_RANGE;
            else
            begin
                unique case (act)
                    iida_pkg::ACT_UPDATE:
                    begin
                        cmd.upd_en    = accept;
                        out_data_next = '0;
                    end
                    iida_pkg::ACT_DELETE:
                    begin
                        cmd.del_en    = accept;
                        out_data_next = rd_bus;
                        count_next    = count_reg - 1'b1;
                    end
                    default:
                    begin
                        out_data_next = rd_bus;
                    end
                endcase
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [iida_pkg::WORD_W-1:0] left_w;
            logic [iida_pkg::WORD_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = words[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = words[g+1];
            end
            iida_cell #(
                .POS (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (words[g]),
                .rd_word    (rd_words[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_bus = rd_bus | rd_words[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= count_next;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.status = out_status_reg;
    assign rsp.count  = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_L)
        else $error("live count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.ins_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == iida_pkg::ST_EMPTY |-> rsp.count == '0)
        else $error("empty status with nonzero count");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.count == count_reg)
        else $error("response count differs from live count");

endmodule

// ===== sv/iida_cell.sv =====
module iida_cell #(
    parameter int POS = 0
) (
    input  logic                          clk,
    input  iida_pkg::cell_cmd_t           cmd,
    input  logic [iida_pkg::WORD_W-1:0]   left_word,
    input  logic [iida_pkg::WORD_W-1:0]   right_word,
    output logic [iida_pkg::WORD_W-1:0]   word,
    output logic [iida_pkg::WORD_W-1:0]   rd_word
);

    localparam logic [iida_pkg::IDX_MAX_W-1:0] POS_L = iida_pkg::IDX_MAX_W'(POS);

    logic [iida_pkg::WORD_W-1:0] entry_reg;
    logic [iida_pkg::WORD_W-1:0] entry_next;
    logic                        hit;

    assign hit = (cmd.index == POS_L);

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.ins_en)
        begin
            if (POS_L > cmd.index)
                entry_next = left_word;
            else if (hit)
                entry_next = cmd.value;
        end
        else if (cmd.upd_en)
        begin
            if (hit)
                entry_next = cmd.value;
        end
        else if (cmd.del_en)
        begin
            if (POS_L >= cmd.index)
                entry_next = right_word;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign word    = entry_reg;
    assign rd_word = hit ? entry_reg : '0;

endmodule
